// ===== sv/zba_pkg.sv =====
// Package for the zone bitmap allocator: field widths, status and opcode codes,
// config register indexes and reset values.
// No dependencies.
package zba_pkg;

  localparam int unsigned MAP_BITS_DEF  = 8192;
  localparam int unsigned WORD_BITS_DEF = 64;

  localparam int unsigned ZONE_W     = 14;
  localparam int unsigned FDZ_W      = 16;
  localparam int unsigned OP_W       = 1;
  localparam int unsigned BLK_W      = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned ALLOC_W    = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // bit index arithmetic: wide enough for any map size plus one word
  localparam int unsigned IDX_W  = 18;
  // bit index of a free request that passed the range check
  localparam int unsigned FREE_W = 17;

  localparam logic [ZONE_W-1:0] ZONE_COUNT_RST = ZONE_W'(8192);
  localparam logic [FDZ_W-1:0]  FDZ_RST        = FDZ_W'(1);

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_ZONE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW_DATA   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

endpackage

// ===== sv/zba_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on zba_pkg for default sizes.
module zba_ram #(
  parameter int unsigned WIDTH = zba_pkg::WORD_BITS_DEF,
  parameter int unsigned DEPTH = zba_pkg::MAP_BITS_DEF / zba_pkg::WORD_BITS_DEF,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/zone_bitmap_allocator.sv =====
// Zone bitmap allocator: first-fit allocate and checked free over a used/free
// bitmap kept in a word-wide RAM. Depends on zba_pkg and zba_ram.
//
//   channel | signals                           | direction
//   cfg     | cfg_write, cfg_index, cfg_data    | in, write only
//   req     | req_valid/req_stall, opcode,      | in
//           | block_number                      |
//   rsp     | rsp_valid/rsp_stall, status,      | out
//           | allocated_block                   |
//
// Allocate: one bitmap word read per cycle, set by the RAM read port; at most
// ceil(min(zone_count, MAP_BITS) / WORD_BITS) words are read (128 at default sizes).
// Free: accept, check, reciprocal divide, bit offset and RAM read, write back, output;
// a request that fails the range checks goes from the check straight to the output.
// After reset a clearing pass writes every word (128 at default sizes); no item is
// taken until it ends. Config writes are taken at any time.
// One item at a time; the next item is taken while a result waits in the output register.
module zone_bitmap_allocator #(
  parameter int unsigned MAP_BITS  = zba_pkg::MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = zba_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [zba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [zba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [zba_pkg::OP_W-1:0]        opcode,
  input  logic [zba_pkg::BLK_W-1:0]       block_number,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [zba_pkg::STATUS_W-1:0]    status,
  output logic [zba_pkg::ALLOC_W-1:0]     allocated_block
);
  import zba_pkg::*;

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned POS_W     = $clog2(WORD_BITS);
  localparam int unsigned REM_W     = $clog2(WORD_BITS + 1);
  localparam int unsigned DIV_S     = FREE_W + POS_W;
  localparam int unsigned RECIP     = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned RECIP_W   = FREE_W + 2;
  localparam int unsigned PROD_W    = FREE_W + RECIP_W;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_FREE_CHK = 8'b0000_1000,
    S_FREE_DIV = 8'b0001_0000,
    S_FREE_RD  = 8'b0010_0000,
    S_FREE_WR  = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  function automatic logic [POS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (v[j]) p = POS_W'(j);
    end
    return p;
  endfunction

  state_t              state;
  logic [ZONE_W-1:0]   zone_count;
  logic [FDZ_W-1:0]    fdz;
  logic [AW-1:0]       clr_ptr;
  logic [BLK_W-1:0]    blk_q;
  logic [IDX_W-1:0]    limit_q;
  logic [IDX_W-1:0]    base;
  logic [IDX_W-1:0]    dbase;
  logic [AW-1:0]       word_ptr;
  logic [AW-1:0]       dword;
  logic [REM_W-1:0]    drem_q;
  logic                rd_pending;
  logic [FREE_W-1:0]   bit_q;
  logic [AW-1:0]       q_q;
  logic [POS_W-1:0]    pos_q;
  logic [STATUS_W-1:0] res_status;
  logic [ALLOC_W-1:0]  res_block;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] rdata;

  logic [WORD_BITS-1:0] free_vec;
  logic                found;
  logic [POS_W-1:0]    scan_pos;
  logic                issue;
  logic [IDX_W-1:0]    rem_full;
  logic [IDX_W-1:0]    zc_ext;
  logic [IDX_W-1:0]    bit_calc;
  logic [IDX_W-1:0]    alloc_sum;
  logic [PROD_W-1:0]   prod;
  logic [FREE_W-1:0]   pos_full;
  logic                ld;

  assign req_stall = (state != S_IDLE);
  assign ld        = (state == S_RESP) && (!rsp_valid || !rsp_stall);
  assign issue     = (base < limit_q);
  assign rem_full  = limit_q - base;
  assign zc_ext    = IDX_W'(zone_count);
  assign bit_calc  = IDX_W'(blk_q) - IDX_W'(fdz) + IDX_W'(1);
  assign prod      = PROD_W'(bit_q) * PROD_W'(RECIP);
  assign pos_full  = bit_q - FREE_W'(q_q * WORD_BITS);
  assign scan_pos  = lowest_set(free_vec);
  assign found     = |free_vec;
  assign alloc_sum = IDX_W'(fdz) + dbase + IDX_W'(scan_pos) - IDX_W'(1);
  assign ram_raddr = (state == S_FREE_RD) ? q_q : word_ptr;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      free_vec[j] = !rdata[j] && (REM_W'(j) < drem_q);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_ptr;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (clr_ptr == '0) ? WORD_BITS'(1) : '0;
      end
      S_SCAN: begin
        ram_we    = rd_pending && found;
        ram_waddr = dword;
        ram_wdata = rdata | (WORD_BITS'(1) << scan_pos);
      end
      S_FREE_WR: begin
        ram_we    = rdata[pos_q];
        ram_waddr = q_q;
        ram_wdata = rdata & ~(WORD_BITS'(1) << pos_q);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  zba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ptr    <= '0;
      rsp_valid  <= 1'b0;
      rd_pending <= 1'b0;
      zone_count <= ZONE_COUNT_RST;
      fdz        <= FDZ_RST;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_ZONE_COUNT:      zone_count <= cfg_data[ZONE_W-1:0];
          CFG_FIRST_DATA_ZONE: fdz        <= cfg_data[FDZ_W-1:0];
        endcase
      end

      if (rsp_valid && !rsp_stall && !ld) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + AW'(1);
          if (clr_ptr == AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            blk_q      <= block_number;
            base       <= '0;
            word_ptr   <= '0;
            rd_pending <= 1'b0;
            limit_q    <= (zc_ext < IDX_W'(MAP_BITS)) ? zc_ext : IDX_W'(MAP_BITS);
            state      <= (opcode == OP_FREE) ? S_FREE_CHK : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pending <= issue;
          if (issue) begin
            dword    <= word_ptr;
            dbase    <= base;
            drem_q   <= (rem_full >= IDX_W'(WORD_BITS)) ? REM_W'(WORD_BITS) : REM_W'(rem_full);
            word_ptr <= word_ptr + AW'(1);
            base     <= base + IDX_W'(WORD_BITS);
          end
          if (rd_pending && found) begin
            res_status <= ST_OK;
            res_block  <= alloc_sum[ALLOC_W-1:0];
            state      <= S_RESP;
          end else if (!issue) begin
            res_status <= ST_NO_SPACE;
            res_block  <= '0;
            state      <= S_RESP;
          end
        end
        S_FREE_CHK: begin
          res_block <= '0;
          if (blk_q < fdz) begin
            res_status <= ST_BELOW_DATA;
            state      <= S_RESP;
          end else if ((blk_q >= BLK_W'(zone_count)) || (bit_calc >= IDX_W'(MAP_BITS))) begin
            res_status <= ST_RANGE;
            state      <= S_RESP;
          end else begin
            bit_q <= bit_calc[FREE_W-1:0];
            state <= S_FREE_DIV;
          end
        end
        S_FREE_DIV: begin
          q_q   <= prod[DIV_S +: AW];
          state <= S_FREE_RD;
        end
        S_FREE_RD: begin
          pos_q <= pos_full[POS_W-1:0];
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          res_status <= rdata[pos_q] ? ST_OK : ST_ALREADY_FREE;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (ld) begin
            rsp_valid       <= 1'b1;
            status          <= res_status;
            allocated_block <= res_block;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a granted block never maps to the reserved bit or below the data area
  a_alloc_above_base: assert property (@(posedge clk) disable iff (rst)
    (ld && res_status == ST_OK && res_block != '0) |-> (res_block >= ALLOC_W'(fdz)))
    else $error("allocated block below data area");

  // write-back during scan or free always flips exactly the chosen bit
  a_writeback_changes: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == S_SCAN || state == S_FREE_WR)) |->
      ($countones(ram_wdata ^ rdata) == 1))
    else $error("bitmap write-back does not change one bit");

  // failed results (any status other than ok) carry no block number
  a_error_no_block: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (allocated_block == '0))
    else $error("error result with nonzero block");
`endif

endmodule

// ===== test/zone_bitmap_allocator_tb.sv =====
// Testbench for zone_bitmap_allocator: directed and random allocate/free traffic under
// varied idling, checked against a bit-level model of the zone map held in a small class.
// Depends on zba_pkg and the zone_bitmap_allocator RTL.
module zone_bitmap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zba_pkg::*;

  localparam int MAP_SIZE = MAP_BITS_DEF;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 166;
  localparam int MAX_GAP = 60;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ALLOC_W-1:0]  block;
  } reply_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class zone_map_tracker;
    bit                used_map [MAP_SIZE];
    logic [ZONE_W-1:0] zone_count;
    logic [FDZ_W-1:0]  data_base;
    int                hi_mark;
    int                errors;
    reply_t            expected_replies [$];

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      used_map[0] = 1'b1;
      zone_count = ZONE_COUNT_RST;
      data_base = FDZ_RST;
      hi_mark = 1;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ZONE_COUNT) zone_count = data[ZONE_W-1:0];
      else if (idx == CFG_FIRST_DATA_ZONE) data_base = data[FDZ_W-1:0];
    endfunction

    function void predict_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
      reply_t r;
      int scan_end;
      int bit_idx;
      r.status = ST_OK;
      r.block = '0;
      if (op == OP_ALLOC) begin
        scan_end = (int'(zone_count) < MAP_SIZE) ? int'(zone_count) : MAP_SIZE;
        r.status = ST_NO_SPACE;
        for (int b = 0; b < scan_end; b++) begin
          if (!used_map[b]) begin
            used_map[b] = 1'b1;
            if (b > hi_mark) hi_mark = b;
            r.block = ALLOC_W'(int'(data_base) + b - 1);
            r.status = ST_OK;
            break;
          end
        end
      end else if (blk < data_base) begin
        r.status = ST_BELOW_DATA;
      end else begin
        bit_idx = int'(blk) - int'(data_base) + 1;
        if (blk >= zone_count || bit_idx >= MAP_SIZE) r.status = ST_RANGE;
        else if (!used_map[bit_idx]) r.status = ST_ALREADY_FREE;
        else used_map[bit_idx] = 1'b0;
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic [ALLOC_W-1:0] blk);
      reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, status %0d block %0d", $time, st, blk);
        return;
      end
      want = expected_replies.pop_front();
      if (st !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d got %0d", $time, want.status, st);
      end
      if (blk !== want.block) begin
        errors++;
        $display("%0t: allocated_block mismatch, expected %0d got %0d",
                 $time, want.block, blk);
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // a bit that is likely set and whose block passes the range check whenever any block does
    function int pick_used_bit();
      int upper;
      int cand;
      upper = hi_mark;
      if (int'(zone_count) - int'(data_base) < upper) upper = int'(zone_count) - int'(data_base);
      if (upper < 1) upper = hi_mark;
      cand = 1;
      for (int t = 0; t < 16; t++) begin
        cand = $urandom_range(upper, 1);
        if (used_map[cand]) return cand;
      end
      return cand;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [OP_W-1:0]       opcode = OP_ALLOC;
  logic [BLK_W-1:0]      block_number = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [ALLOC_W-1:0]    allocated_block;

  zone_map_tracker tracker;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;

  zone_bitmap_allocator uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode(opcode),
    .block_number(block_number),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .allocated_block(allocated_block)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) tracker.write_reg(cfg_index, cfg_data);
      if (rsp_valid === 1'b1 && !rsp_stall) tracker.check_reply(status, allocated_block);
      if (req_valid && req_stall === 1'b0) tracker.predict_request(opcode, block_number);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic set_idle(idle_mode_t m);
    send_idle_pct = (m == IDLE_SENDER) ? 85 : (m == IDLE_BOTH) ? 22 : 0;
    recv_stall_pct = (m == IDLE_RECEIVER) ? 85 : (m == IDLE_BOTH) ? 22 : 0;
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    opcode <= op;
    block_number <= blk;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] zones, logic [CFG_DATA_W-1:0] base);
    drain();
    write_reg(CFG_ZONE_COUNT, zones);
    write_reg(CFG_FIRST_DATA_ZONE, base);
  endtask

  task automatic run_traffic(int n);
    int pick;
    logic [BLK_W-1:0] blk;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 52) begin
        send_item(OP_ALLOC, BLK_W'($urandom));
      end else if (pick < 86) begin
        send_item(OP_FREE, BLK_W'(int'(tracker.data_base) + tracker.pick_used_bit() - 1));
      end else begin
        case ($urandom_range(5))
          0: blk = BLK_W'($urandom_range(65535));
          1: blk = tracker.data_base - 1'b1;
          2: blk = BLK_W'(tracker.zone_count);
          3: blk = BLK_W'(tracker.zone_count) - 1'b1;
          4: blk = BLK_W'(int'(tracker.data_base) + MAP_SIZE - 1);
          default: blk = BLK_W'(int'(tracker.data_base) + tracker.hi_mark);
        endcase
        send_item(OP_FREE, blk);
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] zone_tab [4];
    logic [CFG_DATA_W-1:0] base_tab [4];
    logic [CFG_DATA_W-1:0] zones;
    logic [CFG_DATA_W-1:0] base;
    zone_tab = '{16'd8192, 16'd48, 16'hFFFF, 16'd300};
    base_tab = '{16'd1, 16'd5, 16'd0, 16'd17};
    tracker = new();
    set_idle(IDLE_NONE);
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // reset settings: first allocations, each free check, double free
    send_item(OP_ALLOC, 16'h0000);
    send_item(OP_ALLOC, 16'hFFFF);
    send_item(OP_FREE, 16'd0);
    send_item(OP_FREE, 16'd8192);
    send_item(OP_FREE, 16'hFFFF);
    send_item(OP_FREE, 16'd2);
    send_item(OP_FREE, 16'd2);
    send_item(OP_FREE, 16'd3);
    send_item(OP_ALLOC, 16'h5A5A);
    // zero zones, then only the reserved bit
    configure(16'd0, 16'd1);
    send_item(OP_ALLOC, 16'd0);
    configure(16'd1, 16'd1);
    send_item(OP_ALLOC, 16'd0);
    send_item(OP_FREE, 16'd1);
    // zone count above map size, data base zero: bit past the map end
    configure(16'hFFFF, 16'd0);
    send_item(OP_FREE, 16'd8191);
    send_item(OP_FREE, 16'd0);
    send_item(OP_ALLOC, 16'd0);
    // top data base: result wider than the block field
    configure(16'hFFFF, 16'hFFFF);
    send_item(OP_ALLOC, 16'd0);
    send_item(OP_FREE, 16'hFFFF);
    send_item(OP_FREE, 16'hFFFE);
    send_item(OP_ALLOC, 16'd0);

    for (int p = 0; p < 8; p++) begin
      if (p < 4) begin
        zones = zone_tab[p];
        base = base_tab[p];
      end else begin
        zones = CFG_DATA_W'($urandom_range(600, 2));
        base = CFG_DATA_W'($urandom_range(int'(zones) / 2, 0));
      end
      configure(zones, base);
      set_idle(idle_mode_t'(p % 4));
      run_traffic(PHASE_ITEMS);
    end

    drain();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
